@@ design/led_pixel_buffer_writer_unit_defines.svh @@
// assertion helpers for the rtl file led_pixel_buffer_writer_unit.sv
`ifndef LED_PIXEL_BUFFER_WRITER_UNIT_DEFINES_SVH
`define LED_PIXEL_BUFFER_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPBW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LPBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lpbw_pkg.sv @@
package lpbw_pkg;

	// default sizing
	localparam int LED_COUNT_DEF = 256;
	localparam int HAS_WHITE_DEF = 1;

	// stream and config widths
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 40;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;

	// commands
	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_SHOW  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// blend modes, anything else replaces
	localparam logic [1:0] BLEND_ADD = 2'd1;
	localparam logic [1:0] BLEND_OR  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIN_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_MODE   = 2'd3;

	localparam logic [7:0] BRIGHT_RESET = 8'd255;
	localparam logic [7:0] PCT_FULL     = 8'd100;

	// 255 * ceil(2^19 / 100): pct * 255 / 100 as multiply and shift
	localparam logic [20:0] SCALE_MUL = 21'd1336965;
	// ceil(2^23 / 255): exact for products below 255 * 253
	localparam logic [15:0] DIV255_MUL = 16'd32897;

	typedef enum logic [3:0] {
		ST_INIT  = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RMW   = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

	// percent to 0..252 channel scale, valid for pct below 100
	function automatic logic [7:0] pct_scale(input logic [7:0] pct);
		logic [28:0] p;
		p = 29'(pct) * 29'(SCALE_MUL);
		return p[26:19];
	endfunction

	// y / 255 for y up to 255 * 252
	function automatic logic [7:0] div255(input logic [15:0] y);
		logic [31:0] p;
		p = 32'(y) * 32'(DIV255_MUL);
		return p[30:23];
	endfunction

endpackage

@@ design/lpbw_mem.sv @@
module lpbw_mem import lpbw_pkg::*; #(
	parameter int DEPTH = LED_COUNT_DEF,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/led_pixel_buffer_writer_unit.sv @@
// set pixel, read pixel, display request: one item at a time, modified in ST_RMW, result registered in the output beat
// clear: sweeps the window clamped at the strip end (or all LED_COUNT LEDs when no window), then gives its beat
// an empty clear goes through ST_RMW like a set; the store has a single write port that paces every sweep
// after arst_n the store is zeroed by a sweep over all LED_COUNT entries with s_tready low
// registers reset to start 0, length 0, limit 255, clamp mode; pending mark clear
`include "led_pixel_buffer_writer_unit_defines.svh"

module led_pixel_buffer_writer_unit import lpbw_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF,
	parameter int HAS_WHITE = HAS_WHITE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// pixel_position[9:0], color_word[41:10], blend_mode[43:42], zero pad
	input  logic [S_DATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// written[0], pixel_value[32:1], display_fire[33], redraw_pending[34], zero pad
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int EW = ($clog2(LED_COUNT + 1) > 10) ? $clog2(LED_COUNT + 1) : 10;
	localparam logic [EW-1:0] LED_END  = EW'(LED_COUNT);
	localparam logic [AW-1:0] LAST_LED = AW'(LED_COUNT - 1);

	state_t st_q;

	logic [7:0]  win_start_q;
	logic [8:0]  win_len_q;
	logic [7:0]  max_bright_q;
	logic        pct_mode_q;
	logic [7:0]  scale_q;
	logic        pend_q;

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] last_q;

	logic [1:0]    cmd_s1;
	logic          hit_s1;
	logic [1:0]    blend_s1;
	logic [31:0]   color_s1;
	logic [15:0]   prod_s1 [4];
	logic [AW-1:0] addr_s1;

	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [31:0]   mem_rdata;

	// input fields
	logic signed [9:0] in_pos;
	logic [31:0]       in_color;
	logic [1:0]        in_blend;
	logic [1:0]        in_cmd;
	assign in_pos   = s_tdata[9:0];
	assign in_color = s_tdata[41:10];
	assign in_blend = s_tdata[43:42];
	assign in_cmd   = s_tuser;

	logic accept;
	assign s_tready = (st_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// address resolve and clear bounds
	logic          win_on;
	logic [EW-1:0] win_sum;
	logic [EW-1:0] lim;
	logic [EW-1:0] abs_addr;
	logic [EW-1:0] clr_lo;
	logic [EW-1:0] clr_last;
	logic          hit;
	logic          clr_empty;

	always_comb begin
		win_on   = (win_len_q != 9'd0);
		win_sum  = EW'(win_start_q) + EW'(win_len_q);
		if (win_on) begin
			lim      = (win_sum > LED_END) ? LED_END : win_sum;
			abs_addr = EW'(win_start_q) + EW'(in_pos[8:0]);
			clr_lo   = EW'(win_start_q);
		end else begin
			lim      = LED_END;
			abs_addr = EW'(in_pos[8:0]);
			clr_lo   = '0;
		end
		hit       = !in_pos[9] && (abs_addr < lim);
		clr_empty = (clr_lo >= lim);
		clr_last  = lim - EW'(1);
	end

	// limit and blend of the stored word
	logic [31:0] new_word;
	always_comb begin
		logic [7:0] c;
		logic [7:0] o;
		logic [8:0] sum;
		logic [7:0] r;
		new_word = '0;
		for (int k = 0; k < 4; k++) begin
			c = color_s1[8*k +: 8];
			if (pct_mode_q) begin
				if (max_bright_q < PCT_FULL) begin
					c = div255(prod_s1[k]);
				end
			end else if (c > max_bright_q) begin
				c = max_bright_q;
			end
			o   = mem_rdata[8*k +: 8];
			sum = 9'(c) + 9'(o);
			case (blend_s1)
				BLEND_ADD: r = sum[8] ? 8'hff : sum[7:0];
				BLEND_OR:  r = c | o;
				default:   r = c;
			endcase
			if (k == 3 && HAS_WHITE == 0) begin
				r = '0;
			end
			new_word[8*k +: 8] = r;
		end
	end

	// store write port: zero sweeps or the modified word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = '0;
		if (st_q == ST_INIT || st_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (st_q == ST_RMW && cmd_s1 == CMD_SET && hit_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = new_word;
		end
	end

	lpbw_mem #(
		.DEPTH (LED_COUNT),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (abs_addr[AW-1:0]),
		.rdata (mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q  <= '0;
			win_len_q    <= '0;
			max_bright_q <= BRIGHT_RESET;
			pct_mode_q   <= 1'b0;
			scale_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIN_START: win_start_q <= cfg_data[7:0];
				REG_WIN_LEN:   win_len_q   <= cfg_data[8:0];
				REG_MAX_BRIGHT: begin
					max_bright_q <= cfg_data[7:0];
					scale_q      <= pct_scale(cfg_data[7:0]);
				end
				REG_PCT_MODE:  pct_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item stage: captured at accept, used in the modify cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= in_cmd;
			hit_s1   <= hit;
			blend_s1 <= in_blend;
			color_s1 <= in_color;
			addr_s1  <= abs_addr[AW-1:0];
			for (int k = 0; k < 4; k++) begin
				prod_s1[k] <= 16'(in_color[8*k +: 8]) * 16'(scale_q);
			end
		end
	end

	// output beat contents from the modify cycle
	logic [M_DATA_W-1:0] rmw_beat;
	logic                rmw_pend;
	always_comb begin
		logic        wr;
		logic [31:0] val;
		logic        fire;
		wr       = 1'b0;
		val      = '0;
		fire     = 1'b0;
		rmw_pend = pend_q;
		case (cmd_s1)
			CMD_SET: begin
				if (hit_s1) begin
					wr       = 1'b1;
					val      = new_word;
					rmw_pend = 1'b1;
				end
			end
			CMD_CLEAR: begin
				wr = 1'b1;
			end
			CMD_SHOW: begin
				fire     = pend_q;
				rmw_pend = 1'b0;
			end
			CMD_READ: begin
				if (hit_s1) begin
					val = mem_rdata;
				end
			end
			default: ;
		endcase
		rmw_beat = M_DATA_W'({rmw_pend, fire, val, wr});
	end

	// sequencer, sweep pointer, pending mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_INIT;
			ptr_q  <= '0;
			last_q <= LAST_LED;
			pend_q <= 1'b0;
		end else begin
			case (st_q)
				ST_INIT, ST_CLEAR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == last_q) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_cmd == CMD_CLEAR) begin
							pend_q <= 1'b1;
						end
						if (in_cmd == CMD_CLEAR && !clr_empty) begin
							st_q   <= ST_CLEAR;
							ptr_q  <= clr_lo[AW-1:0];
							last_q <= clr_last[AW-1:0];
						end else begin
							st_q <= ST_RMW;
						end
					end
				end
				ST_RMW: begin
					pend_q <= rmw_pend;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// output register loads at the end of a clear sweep or of the modify cycle
	logic                out_load;
	logic [M_DATA_W-1:0] out_next;
	assign out_load = (st_q == ST_RMW) || (st_q == ST_CLEAR && ptr_q == last_q);
	assign out_next = (st_q == ST_RMW) ? rmw_beat : M_DATA_W'({1'b1, 1'b0, 32'd0, 1'b1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_data_q  <= out_next;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// one item in flight at a time
	`LPBW_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "item accepted while previous still in work")
	// sweeps only ever write zeros
	`LPBW_ASSERT_NOW(a_sweep_zero, clk, arst_n, st_q == ST_INIT || st_q == ST_CLEAR, mem_we && mem_wdata == 32'd0, "sweep cycle without zero write")
	// a fired display leaves nothing pending
	`LPBW_ASSERT_NOW(a_fire_clears, clk, arst_n, m_tvalid && m_tdata[33], !m_tdata[34], "display fired but pending mark still set")
	// no beat while the store is zeroed after reset
	`LPBW_ASSERT_NOW(a_init_quiet, clk, arst_n, st_q == ST_INIT, !s_tready && !m_tvalid, "activity during reset sweep")

endmodule

@@ verif/led_pixel_buffer_writer_unit_tb.sv @@
module led_pixel_buffer_writer_unit_tb;
	import lpbw_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int LONG_HOLD  = 400;
	localparam int PHASE_LEN  = 125;

	// blend codes the package leaves implicit, both replace
	localparam logic [1:0] BLEND_REPLACE     = 2'd0;
	localparam logic [1:0] BLEND_ALT_REPLACE = 2'd3;

	typedef struct {
		logic [1:0]        cmd;
		logic signed [9:0] pos;
		logic [31:0]       color;
		logic [1:0]        blend;
	} led_cmd_t;

	typedef struct {
		bit          written;
		logic [31:0] value;
		bit          fire;
		bit          pending;
	} led_resp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// shadow of the frame store and its registers
	logic [31:0] led_mem [LED_COUNT_DEF] = '{default: '0};
	bit          redraw_mark = 1'b0;
	logic [7:0]  win_start = 8'd0;
	logic [8:0]  win_len = 9'd0;
	logic [7:0]  bright_max = BRIGHT_RESET;
	bit          pct_mode = 1'b0;

	led_cmd_t  cmd_feed_q [$];
	led_resp_t resp_expect_q [$];
	int        cmds_queued = 0;
	int        resps_seen = 0;
	int        mismatch_count = 0;
	int        recent_pos = 0;

	// pacing knobs shared with the driver and monitor
	bit        src_burst = 1'b0;
	bit        src_no_gaps = 1'b0;
	bit        src_next_valid;
	int        src_gap = 0;
	led_cmd_t  src_cur;
	bit        snk_burst = 1'b0;
	int        snk_wait = 0;
	int        stall_reqs = 0;
	int        stall_served = 0;
	led_resp_t snk_exp;

	led_pixel_buffer_writer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// map a signed position onto a store index, return 0 when the write is dropped
	function automatic bit locate(input logic signed [9:0] pos, output int idx);
		int p;
		int lim;
		p = pos;
		idx = 0;
		if (p < 0)
			return 1'b0;
		if (win_len != 0) begin
			lim = win_start + win_len;
			if (lim > LED_COUNT_DEF)
				lim = LED_COUNT_DEF;
			idx = win_start + p;
			return idx < lim;
		end
		idx = p;
		return p < LED_COUNT_DEF;
	endfunction

	// brightness limit on one 8-bit channel
	function automatic int dim_channel(input int c);
		int scale;
		if (pct_mode) begin
			if (bright_max < PCT_FULL) begin
				scale = (bright_max * 255) / PCT_FULL;
				c = (c * scale) / 255;
			end
		end else if (c > bright_max) begin
			c = bright_max;
		end
		return c;
	endfunction

	// apply one command to the shadow store and return the response it gives
	function automatic led_resp_t predict_led_resp(input led_cmd_t it);
		led_resp_t   r;
		int          idx;
		int          lo;
		int          hi;
		int          c;
		int          o;
		int          x;
		logic [31:0] word;
		r = '{default: 0};
		case (it.cmd)
			CMD_SET: begin
				if (locate(it.pos, idx)) begin
					word = '0;
					for (int sh = 0; sh < 32; sh += 8) begin
						if (sh != 24 || HAS_WHITE_DEF != 0) begin
							c = dim_channel((it.color >> sh) & 32'hff);
							o = (led_mem[idx] >> sh) & 32'hff;
							if (it.blend == BLEND_ADD)
								x = (c + o > 255) ? 255 : c + o;
							else if (it.blend == BLEND_OR)
								x = c | o;
							else
								x = c;
							word |= 32'(x) << sh;
						end
					end
					led_mem[idx] = word;
					redraw_mark = 1'b1;
					r.written = 1'b1;
					r.value = word;
				end
			end
			CMD_CLEAR: begin
				lo = 0;
				hi = LED_COUNT_DEF;
				if (win_len != 0) begin
					lo = win_start;
					hi = win_start + win_len;
					if (hi > LED_COUNT_DEF)
						hi = LED_COUNT_DEF;
				end
				for (int i = lo; i < hi; i++)
					led_mem[i] = '0;
				redraw_mark = 1'b1;
				r.written = 1'b1;
			end
			CMD_SHOW: begin
				if (redraw_mark) begin
					r.fire = 1'b1;
					redraw_mark = 1'b0;
				end
			end
			default: begin
				if (locate(it.pos, idx))
					r.value = led_mem[idx];
			end
		endcase
		r.pending = redraw_mark;
		return r;
	endfunction

	// source side: one beat per queued command, random gap after each unless in a burst or a no-gap phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			src_next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				resp_expect_q.push_back(predict_led_resp(src_cur));
				src_next_valid = 1'b0;
			end
			if (!src_next_valid) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (cmd_feed_q.size() > 0) begin
					src_cur = cmd_feed_q.pop_front();
					s_tdata <= {4'b0, src_cur.blend, src_cur.color, src_cur.pos};
					s_tuser <= src_cur.cmd;
					src_next_valid = 1'b1;
					if ($urandom_range(0, 29) == 0)
						src_burst = !src_burst;
					src_gap = (src_burst || src_no_gaps) ? 0 : $urandom_range(0, 19);
				end
			end
			s_tvalid <= src_next_valid;
		end
	end

	// sink side: check each result beat, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				resps_seen++;
				if (resp_expect_q.size() == 0) begin
					$error("result beat with no command waiting: %h", m_tdata);
					mismatch_count++;
				end else begin
					snk_exp = resp_expect_q.pop_front();
					if (m_tdata[0] !== snk_exp.written) begin
						$error("written: expected %0d, got %0d", snk_exp.written, m_tdata[0]);
						mismatch_count++;
					end
					if (m_tdata[32:1] !== snk_exp.value) begin
						$error("pixel_value: expected %h, got %h", snk_exp.value, m_tdata[32:1]);
						mismatch_count++;
					end
					if (m_tdata[33] !== snk_exp.fire) begin
						$error("display_fire: expected %0d, got %0d", snk_exp.fire, m_tdata[33]);
						mismatch_count++;
					end
					if (m_tdata[34] !== snk_exp.pending) begin
						$error("redraw_pending: expected %0d, got %0d", snk_exp.pending,
							m_tdata[34]);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 29) == 0)
					snk_burst = !snk_burst;
				snk_wait = snk_burst ? 0 : $urandom_range(0, 19);
			end
			if (stall_reqs != stall_served) begin
				stall_served = stall_reqs;
				snk_wait = LONG_HOLD;
			end
			if (snk_wait > 0) begin
				snk_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_cmd(input logic [1:0] cmd, input int pos, input logic [31:0] color,
		input logic [1:0] blend);
		led_cmd_t it;
		it.cmd = cmd;
		it.pos = 10'(pos);
		it.color = color;
		it.blend = blend;
		cmd_feed_q.push_back(it);
		cmds_queued++;
	endtask

	task automatic wait_drained();
		while (resps_seen != cmds_queued)
			@(posedge clk);
	endtask

	// write all four registers in one burst on the config channel
	task automatic cfg_program(input int ws, input int wl, input int mb, input int pm);
		logic [CFG_IDX_W-1:0] regs [4];
		logic [CFG_DAT_W-1:0] vals [4];
		logic [CFG_DAT_W-1:0] junk;
		junk = CFG_DAT_W'($urandom);
		regs = '{REG_WIN_START, REG_WIN_LEN, REG_MAX_BRIGHT, REG_PCT_MODE};
		// spare upper bits carry noise, the block keeps only the register width
		vals[0] = {junk[8], ws[7:0]};
		vals[1] = wl[8:0];
		vals[2] = {junk[8], mb[7:0]};
		vals[3] = {junk[8:1], pm[0]};
		for (int k = 0; k < 4; k++) begin
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			case (regs[k])
				REG_WIN_START:  win_start = vals[k][7:0];
				REG_WIN_LEN:    win_len = vals[k];
				REG_MAX_BRIGHT: bright_max = vals[k][7:0];
				REG_PCT_MODE:   pct_mode = vals[k][0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// let a trailing clear sweep finish before touching the registers
	task automatic retune(input int ws, input int wl, input int mb, input int pm);
		wait_drained();
		repeat (LED_COUNT_DEF + 8)
			@(posedge clk);
		cfg_program(ws, wl, mb, pm);
	endtask

	task automatic push_random_cmd();
		led_cmd_t    it;
		int          span;
		int          pick;
		int          pos;
		int          idx;
		logic [31:0] color;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			it.cmd = CMD_SET;
		else if (pick < 74)
			it.cmd = CMD_READ;
		else if (pick < 90)
			it.cmd = CMD_SHOW;
		else
			it.cmd = CMD_CLEAR;
		// whole-strip clears are slow, keep most clears to small windows
		if (it.cmd == CMD_CLEAR && (win_len == 0 || win_len > 64) && $urandom_range(0, 3) != 0)
			it.cmd = CMD_SET;
		span = LED_COUNT_DEF;
		if (win_len != 0) begin
			span = win_start + win_len;
			if (span > LED_COUNT_DEF)
				span = LED_COUNT_DEF;
			span -= win_start;
		end
		pick = $urandom_range(0, 9);
		if (it.cmd == CMD_READ && $urandom_range(0, 1) == 0)
			pos = recent_pos;
		else if (pick < 7 && span > 0)
			pos = $urandom_range(0, span - 1);
		else if (pick < 8)
			pos = recent_pos;
		else
			pos = $urandom_range(0, 1023);
		for (int sh = 0; sh < 32; sh += 8) begin
			pick = $urandom_range(0, 3);
			color[sh +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
		end
		if (it.cmd == CMD_SET && locate(10'(pos), idx))
			recent_pos = pos;
		push_cmd(it.cmd, pos, color, 2'($urandom_range(0, 3)));
	endtask

	task automatic run_phase(input int ws, input int wl, input int mb, input int pm,
		input bit hold_sink, input bit mid_pause);
		retune(ws, wl, mb, pm);
		if (hold_sink) begin
			src_no_gaps = 1'b1;
			stall_reqs++;
		end
		for (int i = 0; i < PHASE_LEN; i++) begin
			if (mid_pause && i == PHASE_LEN / 2)
				wait_drained();
			push_random_cmd();
		end
		wait_drained();
		src_no_gaps = 1'b0;
	endtask

	// stimulus: directed corners, then random phases over several settings
	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		// reset settings: whole strip, full brightness, clamp
		push_cmd(CMD_SHOW, 0, 32'h0, BLEND_REPLACE);
		push_cmd(CMD_SET, 0, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_SET, 255, 32'h12345678, BLEND_REPLACE);
		push_cmd(CMD_SET, 256, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_SET, -1, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_SET, -512, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_SET, 511, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_SET, 255, 32'hf0f0f0f0, BLEND_ADD);
		push_cmd(CMD_SET, 255, 32'h0f0f0f01, BLEND_OR);
		push_cmd(CMD_SET, 255, 32'ha5a5a5a5, BLEND_ALT_REPLACE);
		push_cmd(CMD_READ, 255, 32'h0, BLEND_REPLACE);
		push_cmd(CMD_READ, -1, 32'h0, BLEND_REPLACE);
		push_cmd(CMD_SHOW, 0, 32'h0, BLEND_REPLACE);
		push_cmd(CMD_SHOW, 0, 32'h0, BLEND_REPLACE);
		push_cmd(CMD_CLEAR, 0, 32'h0, BLEND_REPLACE);
		push_cmd(CMD_READ, 0, 32'h0, BLEND_REPLACE);

		// window running past the strip end, clamp limit
		retune(250, 256, 200, 0);
		push_cmd(CMD_SET, 5, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_SET, 6, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_CLEAR, 0, 32'h0, BLEND_REPLACE);
		push_cmd(CMD_READ, 5, 32'h0, BLEND_REPLACE);

		// one-led window with percent scaling just under full
		retune(0, 1, 99, 1);
		push_cmd(CMD_SET, 0, 32'hffffffff, BLEND_REPLACE);
		push_cmd(CMD_READ, 1, 32'h0, BLEND_REPLACE);

		// zero limit in both modes
		retune(0, 0, 0, 1);
		push_cmd(CMD_SET, 7, 32'hffffffff, BLEND_REPLACE);
		retune(0, 0, 0, 0);
		push_cmd(CMD_SET, 8, 32'hffffffff, BLEND_ADD);
		push_cmd(CMD_SHOW, 0, 32'h0, BLEND_REPLACE);

		run_phase(0, 0, 255, 0, 1'b0, 1'b0);
		run_phase(255, 256, 0, 1, 1'b0, 1'b0);
		run_phase(0, 256, 255, 1, 1'b0, 1'b0);
		run_phase(128, 1, 99, 1, 1'b0, 1'b0);
		run_phase(17, 40, 0, 0, 1'b1, 1'b0);
		run_phase(0, 0, 50, 1, 1'b0, 1'b1);
		for (int p = 0; p < 7; p++) begin
			run_phase($urandom_range(0, 255),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 256) : $urandom_range(0, 48),
				($urandom_range(0, 1) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 255),
				$urandom_range(0, 1), 1'b0, 1'b0);
		end

		wait_drained();
		repeat (LED_COUNT_DEF + 16)
			@(posedge clk);
		if (mismatch_count == 0 && resp_expect_q.size() == 0)
			$display("led_pixel_buffer_writer_unit regression: pass");
		else
			$display("led_pixel_buffer_writer_unit regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#(CLK_PERIOD * 3000000);
		$display("led_pixel_buffer_writer_unit regression: fail");
		$finish;
	end

endmodule
